@@ hw/rtl/stce_pkg.sv @@
// Shared types, scan code names and key translation ROM for the scan code text cursor engine.
// No dependencies; every other file of the block imports this package.
package stce_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int MAP_SIZE = 59;

   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CHAR_W  = 7;
   localparam int CODE_W  = 8;
   localparam int COLOR_W = 8;

   localparam logic [ROW_W-1:0]   LAST_ROW    = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]   LAST_COL    = COL_W'(COLUMNS - 1);
   localparam logic [CODE_W-1:0]  MAP_LIMIT   = CODE_W'(MAP_SIZE);
   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

   localparam logic [CODE_W-1:0] SC_BACKSPACE    = 8'h0E;
   localparam logic [CODE_W-1:0] SC_LEFT         = 8'h4B;
   localparam logic [CODE_W-1:0] SC_ENTER        = 8'h1C;
   localparam logic [CODE_W-1:0] SC_RIGHT        = 8'h4D;
   localparam logic [CODE_W-1:0] SC_UP           = 8'h48;
   localparam logic [CODE_W-1:0] SC_DOWN         = 8'h50;
   localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [CODE_W-1:0] SC_IGNORED      = 8'h03;

   localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_Z = 7'h7A;
   localparam logic [CHAR_W-1:0] CASE_GAP = 7'h20;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             shift;
   } stce_state_type;

   typedef struct packed {
      logic               write_valid;
      logic [CHAR_W-1:0]  write_char;
      logic [COLOR_W-1:0] write_color;
      logic [ROW_W-1:0]   write_row;
      logic [COL_W-1:0]   write_col;
      logic               cursor_valid;
      logic [ROW_W-1:0]   cursor_row;
      logic [COL_W-1:0]   cursor_col;
   } stce_rsp_type;

   function automatic logic [CHAR_W-1:0] stce_key_rom(input logic [5:0] idx);
      logic [CHAR_W-1:0] ch;
      case (idx)
         6'd2:    ch = 7'h31;
         6'd3:    ch = 7'h32;
         6'd4:    ch = 7'h33;
         6'd5:    ch = 7'h34;
         6'd6:    ch = 7'h35;
         6'd7:    ch = 7'h36;
         6'd8:    ch = 7'h37;
         6'd9:    ch = 7'h38;
         6'd10:   ch = 7'h39;
         6'd11:   ch = 7'h30;
         6'd12:   ch = 7'h2D;
         6'd13:   ch = 7'h3D;
         6'd16:   ch = 7'h71;
         6'd17:   ch = 7'h77;
         6'd18:   ch = 7'h65;
         6'd19:   ch = 7'h72;
         6'd20:   ch = 7'h74;
         6'd21:   ch = 7'h79;
         6'd22:   ch = 7'h75;
         6'd23:   ch = 7'h69;
         6'd24:   ch = 7'h6F;
         6'd25:   ch = 7'h70;
         6'd26:   ch = 7'h5B;
         6'd27:   ch = 7'h5D;
         6'd28:   ch = 7'h0A;
         6'd30:   ch = 7'h61;
         6'd31:   ch = 7'h73;
         6'd32:   ch = 7'h64;
         6'd33:   ch = 7'h66;
         6'd34:   ch = 7'h67;
         6'd35:   ch = 7'h68;
         6'd36:   ch = 7'h6A;
         6'd37:   ch = 7'h6B;
         6'd38:   ch = 7'h6C;
         6'd39:   ch = 7'h3B;
         6'd40:   ch = 7'h27;
         6'd41:   ch = 7'h60;
         6'd43:   ch = 7'h5C;
         6'd44:   ch = 7'h7A;
         6'd45:   ch = 7'h78;
         6'd46:   ch = 7'h63;
         6'd47:   ch = 7'h76;
         6'd48:   ch = 7'h62;
         6'd49:   ch = 7'h6E;
         6'd50:   ch = 7'h6D;
         6'd51:   ch = 7'h2C;
         6'd52:   ch = 7'h2E;
         6'd53:   ch = 7'h2F;
         6'd55:   ch = 7'h2A;
         6'd57:   ch = 7'h20;
         default: ch = CH_NONE;
      endcase
      return ch;
   endfunction

endpackage

@@ hw/rtl/stce_req_if.sv @@
// Scan code request channel: valid/ready handshake carrying one scan code byte.
// Depends on stce_pkg for the code width.
interface stce_req_if;
   import stce_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

@@ hw/rtl/stce_rsp_if.sv @@
// Response channel: valid/ready handshake carrying the cell write and cursor move fields.
// Depends on stce_pkg for the field widths.
interface stce_rsp_if;
   import stce_pkg::*;

   logic               valid;
   logic               ready;
   logic               write_valid;
   logic [CHAR_W-1:0]  write_char;
   logic [COLOR_W-1:0] write_color;
   logic [ROW_W-1:0]   write_row;
   logic [COL_W-1:0]   write_col;
   logic               cursor_valid;
   logic [ROW_W-1:0]   cursor_row;
   logic [COL_W-1:0]   cursor_col;

   modport source (output valid, output write_valid, output write_char, output write_color,
                   output write_row, output write_col, output cursor_valid,
                   output cursor_row, output cursor_col, input ready);
   modport sink   (input valid, input write_valid, input write_char, input write_color,
                   input write_row, input write_col, input cursor_valid,
                   input cursor_row, input cursor_col, output ready);
endinterface

@@ hw/rtl/stce_decode.sv @@
// Combinational decode of one scan code against the cursor state: next state and response.
// Depends on stce_pkg for types, scan code names and the key ROM.
module stce_decode (
   input  logic [stce_pkg::CODE_W-1:0]  code,
   input  logic [stce_pkg::COLOR_W-1:0] color,
   input  stce_pkg::stce_state_type     cur,
   output stce_pkg::stce_state_type     nxt,
   output stce_pkg::stce_rsp_type       rsp
);
   import stce_pkg::*;

   logic [COL_W-1:0]  col_inc;
   logic [COL_W-1:0]  col_dec;
   logic [COL_W-1:0]  col_adv;
   logic [ROW_W-1:0]  row_inc;
   logic [ROW_W-1:0]  row_dec;
   logic [ROW_W-1:0]  row_adv;
   logic              col_at_end;
   logic              row_at_end;
   logic              mapped;
   logic [CHAR_W-1:0] rom_ch;
   logic [CHAR_W-1:0] shown_ch;

   assign col_at_end = (cur.col >= LAST_COL);
   assign row_at_end = (cur.row >= LAST_ROW);
   assign col_inc    = cur.col + COL_W'(1);
   assign col_dec    = cur.col - COL_W'(1);
   assign row_inc    = cur.row + ROW_W'(1);
   assign row_dec    = cur.row - ROW_W'(1);
   assign col_adv    = col_at_end ? cur.col : col_inc;
   assign row_adv    = row_at_end ? cur.row : row_inc;
   assign mapped     = (code < MAP_LIMIT) && (code != SC_IGNORED);
   assign rom_ch     = stce_key_rom(code[5:0]);
   assign shown_ch   = (cur.shift && rom_ch >= CH_LOW_A && rom_ch <= CH_LOW_Z)
                       ? rom_ch - CASE_GAP : rom_ch;

   always_comb begin
      nxt = cur;
      rsp = '0;
      unique case (code) inside
         SC_BACKSPACE: begin
            if (cur.col != '0) begin
               nxt.col          = col_dec;
               rsp.write_valid  = 1'b1;
               rsp.write_char   = CH_SPACE;
               rsp.write_color  = color;
               rsp.write_row    = cur.row;
               rsp.write_col    = col_dec;
               rsp.cursor_valid = 1'b1;
               rsp.cursor_row   = cur.row;
               rsp.cursor_col   = col_dec;
            end
         end
         SC_LEFT: begin
            if (cur.col != '0) begin
               nxt.col          = col_dec;
               rsp.cursor_valid = 1'b1;
               rsp.cursor_row   = cur.row;
               rsp.cursor_col   = col_dec;
            end
         end
         SC_ENTER: begin
            nxt.row          = row_adv;
            nxt.col          = '0;
            rsp.cursor_valid = 1'b1;
            rsp.cursor_row   = row_adv;
            rsp.cursor_col   = '0;
         end
         SC_RIGHT: begin
            if (!col_at_end) begin
               nxt.col          = col_inc;
               rsp.cursor_valid = 1'b1;
               rsp.cursor_row   = cur.row;
               rsp.cursor_col   = col_inc;
            end
         end
         SC_UP: begin
            if (cur.row != '0) begin
               nxt.row          = row_dec;
               rsp.cursor_valid = 1'b1;
               rsp.cursor_row   = row_dec;
               rsp.cursor_col   = cur.col;
            end
         end
         SC_DOWN: begin
            if (!row_at_end) begin
               nxt.row          = row_inc;
               rsp.cursor_valid = 1'b1;
               rsp.cursor_row   = row_inc;
               rsp.cursor_col   = cur.col;
            end
         end
         SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: begin
            nxt.shift = 1'b1;
         end
         SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: begin
            nxt.shift = 1'b0;
         end
         default: begin
            if (mapped && rom_ch == CH_SPACE) begin
               nxt.col          = col_adv;
               rsp.write_valid  = 1'b1;
               rsp.write_char   = CH_SPACE;
               rsp.write_color  = color;
               rsp.write_row    = cur.row;
               rsp.write_col    = col_adv;
               rsp.cursor_valid = 1'b1;
               rsp.cursor_row   = cur.row;
               rsp.cursor_col   = col_adv;
            end else if (mapped && rom_ch != CH_NONE) begin
               nxt.col          = col_adv;
               rsp.write_valid  = 1'b1;
               rsp.write_char   = shown_ch;
               rsp.write_color  = color;
               rsp.write_row    = cur.row;
               rsp.write_col    = cur.col;
            end
         end
      endcase
   end

endmodule

@@ hw/rtl/scancode_text_cursor_engine.sv @@
// Top level of the scan code text cursor engine: input register, decode, response register.
// Depends on stce_pkg, stce_req_if, stce_rsp_if and stce_decode.
//
// Usage:
//   req_chan carries one set-1 scan code per transaction; rsp_chan returns exactly one
//   response per accepted code, holding an optional character cell write and an optional
//   cursor move (fields are zero where their valid flag is low).
//   csr_wr_en/csr_wr_data write the text colour attribute; change it only while idle.
// Path: a code taken into the input register is decoded into the response register.
// Throughput: one code per cycle when rsp_chan does not stall; cursor and shift state is
//   read and updated in the single decode step between the input and response registers.
// Reset: clears both valid stages, puts the cursor at row 0 column 0, releases shift and
//   sets the colour to 7.
// Stall: while rsp_chan.ready is low the response holds; the input register still takes
//   one more code, and req_chan.ready falls only when both stages are full.
module scancode_text_cursor_engine (
   input logic                          clock,
   input logic                          reset,
   stce_req_if.sink                     req_chan,
   stce_rsp_if.source                   rsp_chan,
   input logic                          csr_wr_en,
   input logic [stce_pkg::COLOR_W-1:0]  csr_wr_data
);
   import stce_pkg::*;

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [CODE_W-1:0]  code_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   stce_rsp_type       rsp_ff;
   stce_state_type     state_ff;
   stce_state_type     state_in;
   logic [COLOR_W-1:0] color_ff;
   logic [COLOR_W-1:0] color_in;
   stce_rsp_type       rsp_in;
   logic               advance;
   logic               take;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign take    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
   assign color_in     = csr_wr_en ? csr_wr_data : color_ff;

   stce_decode u_decode (
      .code  (code_ff),
      .color (color_ff),
      .cur   (state_ff),
      .nxt   (state_in),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         color_ff     <= COLOR_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         color_ff     <= color_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         code_ff <= req_chan.scan_code;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.write_valid  = rsp_ff.write_valid;
   assign rsp_chan.write_char   = rsp_ff.write_char;
   assign rsp_chan.write_color  = rsp_ff.write_color;
   assign rsp_chan.write_row    = rsp_ff.write_row;
   assign rsp_chan.write_col    = rsp_ff.write_col;
   assign rsp_chan.cursor_valid = rsp_ff.cursor_valid;
   assign rsp_chan.cursor_row   = rsp_ff.cursor_row;
   assign rsp_chan.cursor_col   = rsp_ff.cursor_col;

endmodule

@@ hw/rtl/stce_check.sv @@
// Port-level checks on the response channel of the scan code text cursor engine.
// Depends on stce_pkg; bound to scancode_text_cursor_engine at the end of this file.
module stce_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          write_valid,
   input logic [stce_pkg::CHAR_W-1:0]   write_char,
   input logic [stce_pkg::COLOR_W-1:0]  write_color,
   input logic [stce_pkg::ROW_W-1:0]    write_row,
   input logic [stce_pkg::COL_W-1:0]    write_col,
   input logic                          cursor_valid,
   input logic [stce_pkg::ROW_W-1:0]    cursor_row,
   input logic [stce_pkg::COL_W-1:0]    cursor_col
);
   import stce_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(write_char) && $stable(write_col)
         && $stable(cursor_row) && $stable(cursor_col) && $stable(write_valid))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !write_valid |-> write_char == '0 && write_color == '0
         && write_row == '0 && write_col == '0)
      else $error("cell write fields set without a write");

   a_cursor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !cursor_valid |-> cursor_row == '0 && cursor_col == '0)
      else $error("cursor fields set without a move");

   a_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> write_row <= LAST_ROW && write_col <= LAST_COL
         && cursor_row <= LAST_ROW && cursor_col <= LAST_COL)
      else $error("position beyond the screen");

endmodule

bind scancode_text_cursor_engine stce_check u_stce_check (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .write_valid  (rsp_chan.write_valid),
   .write_char   (rsp_chan.write_char),
   .write_color  (rsp_chan.write_color),
   .write_row    (rsp_chan.write_row),
   .write_col    (rsp_chan.write_col),
   .cursor_valid (rsp_chan.cursor_valid),
   .cursor_row   (rsp_chan.cursor_row),
   .cursor_col   (rsp_chan.cursor_col)
);

@@ sim/scancode_text_cursor_engine_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for scancode_text_cursor_engine: directed and random scan codes,
// an in-bench cursor and shift predictor, and random stalls on both channels.
// Depends on stce_pkg, stce_req_if, stce_rsp_if and the engine RTL.
module scancode_text_cursor_engine_tb;
   import stce_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [CODE_W-1:0] SC_ESC         = 8'h01;
   localparam logic [CODE_W-1:0] SC_KEY_1       = 8'h02;
   localparam logic [CODE_W-1:0] SC_KEY_Q       = 8'h10;
   localparam logic [CODE_W-1:0] SC_KEY_A       = 8'h1E;
   localparam logic [CODE_W-1:0] SC_KEY_Z       = 8'h2C;
   localparam logic [CODE_W-1:0] SC_SLASH       = 8'h35;
   localparam logic [CODE_W-1:0] SC_KEYPAD_STAR = 8'h37;
   localparam logic [CODE_W-1:0] SC_SPACE       = 8'h39;
   localparam logic [CODE_W-1:0] SC_CAPS        = 8'h3A;
   localparam logic [CODE_W-1:0] SC_F1          = 8'h3B;
   localparam logic [CODE_W-1:0] SC_NULL        = 8'h00;
   localparam logic [CODE_W-1:0] SC_ESC_BREAK   = 8'h81;
   localparam logic [CODE_W-1:0] SC_ALL_ONES    = 8'hFF;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [COLOR_W-1:0] csr_wr_data;

   stce_req_if req_chan();
   stce_rsp_if rsp_chan();

   scancode_text_cursor_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // '~' marks a code with no character
   string key_map = "~~1234567890-=~~qwertyuiop[]\n~asdfghjkl;'`~\\zxcvbnm,./~*~ ~";

   logic [CODE_W-1:0]  keystrokes[$];
   stce_rsp_type       pending_updates[$];
   logic [ROW_W-1:0]   caret_row;
   logic [COL_W-1:0]   caret_col;
   logic               shift_down;
   logic [COLOR_W-1:0] cell_color;
   int                 send_idle_pct;
   int                 recv_idle_pct;
   int                 mismatch_count;
   int                 quiet_cycles;

   function automatic logic [CHAR_W-1:0] key_char(input logic [CODE_W-1:0] code);
      byte c;
      c = key_map[code];
      return (c == "~") ? CH_NONE : c[CHAR_W-1:0];
   endfunction

   function automatic stce_rsp_type screen_update(input logic [CODE_W-1:0] code);
      stce_rsp_type       upd;
      logic               put_cell;
      logic               move_caret;
      logic [CHAR_W-1:0]  ch;
      logic [ROW_W-1:0]   cell_row;
      logic [COL_W-1:0]   cell_col;
      upd        = '0;
      put_cell   = 1'b0;
      move_caret = 1'b0;
      ch         = CH_NONE;
      cell_row   = '0;
      cell_col   = '0;
      case (code)
         SC_BACKSPACE: begin
            if (caret_col != 0) begin
               caret_col  = caret_col - COL_W'(1);
               put_cell   = 1'b1;
               ch         = CH_SPACE;
               cell_row   = caret_row;
               cell_col   = caret_col;
               move_caret = 1'b1;
            end
         end
         SC_LEFT: begin
            if (caret_col != 0) begin
               caret_col  = caret_col - COL_W'(1);
               move_caret = 1'b1;
            end
         end
         SC_RIGHT: begin
            if (caret_col < LAST_COL) begin
               caret_col  = caret_col + COL_W'(1);
               move_caret = 1'b1;
            end
         end
         SC_UP: begin
            if (caret_row != 0) begin
               caret_row  = caret_row - ROW_W'(1);
               move_caret = 1'b1;
            end
         end
         SC_DOWN: begin
            if (caret_row < LAST_ROW) begin
               caret_row  = caret_row + ROW_W'(1);
               move_caret = 1'b1;
            end
         end
         SC_ENTER: begin
            if (caret_row < LAST_ROW) caret_row = caret_row + ROW_W'(1);
            caret_col  = '0;
            move_caret = 1'b1;
         end
         SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: shift_down = 1'b1;
         SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_down = 1'b0;
         default: begin
            if (code < MAP_LIMIT && code != SC_IGNORED) begin
               ch = key_char(code);
               if (ch == CH_SPACE) begin
                  if (caret_col < LAST_COL) caret_col = caret_col + COL_W'(1);
                  put_cell   = 1'b1;
                  cell_row   = caret_row;
                  cell_col   = caret_col;
                  move_caret = 1'b1;
               end else if (ch != CH_NONE) begin
                  if (shift_down && ch >= CH_LOW_A && ch <= CH_LOW_Z) ch = ch - CASE_GAP;
                  put_cell = 1'b1;
                  cell_row = caret_row;
                  cell_col = caret_col;
                  if (caret_col < LAST_COL) caret_col = caret_col + COL_W'(1);
               end
            end
         end
      endcase
      if (put_cell) begin
         upd.write_valid = 1'b1;
         upd.write_char  = ch;
         upd.write_color = cell_color;
         upd.write_row   = cell_row;
         upd.write_col   = cell_col;
      end
      if (move_caret) begin
         upd.cursor_valid = 1'b1;
         upd.cursor_row   = caret_row;
         upd.cursor_col   = caret_col;
      end
      return upd;
   endfunction

   function automatic string describe(input stce_rsp_type r);
      return $sformatf("write %0b char %h colour %h at %0d,%0d / cursor %0b at %0d,%0d",
                       r.write_valid, r.write_char, r.write_color, r.write_row, r.write_col,
                       r.cursor_valid, r.cursor_row, r.cursor_col);
   endfunction

   // first six are the cursor movers
   function automatic logic [CODE_W-1:0] named_key(input int n);
      case (n)
         0:       return SC_BACKSPACE;
         1:       return SC_LEFT;
         2:       return SC_RIGHT;
         3:       return SC_UP;
         4:       return SC_DOWN;
         5:       return SC_ENTER;
         6:       return SC_LSHIFT_MAKE;
         7:       return SC_RSHIFT_MAKE;
         8:       return SC_LSHIFT_BREAK;
         9:       return SC_RSHIFT_BREAK;
         10:      return SC_IGNORED;
         default: return SC_SPACE;
      endcase
   endfunction

   task automatic add_random_keystrokes(input int wanted);
      int made;
      int kind;
      int run;
      int sel;
      int i;
      logic [CODE_W-1:0] key;
      made = 0;
      while (made < wanted) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            run = $urandom_range(100, 1);
            for (i = 0; i < run; i++) begin
               sel = $urandom_range(99);
               if (sel < 6)       key = named_key($urandom_range(7, 6));
               else if (sel < 12) key = named_key($urandom_range(9, 8));
               else if (sel < 18) key = SC_SPACE;
               else if (sel < 22) key = SC_BACKSPACE;
               else               key = CODE_W'($urandom_range(MAP_SIZE - 1));
               keystrokes.push_back(key);
               made++;
            end
         end else if (kind < 65) begin
            key = named_key($urandom_range(5));
            run = $urandom_range(90, 1);
            for (i = 0; i < run; i++) begin
               keystrokes.push_back(key);
               made++;
            end
         end else if (kind < 85) begin
            run = $urandom_range(20, 1);
            for (i = 0; i < run; i++) begin
               if ($urandom_range(3) == 0) key = CODE_W'($urandom_range(255));
               else                        key = named_key($urandom_range(11));
               keystrokes.push_back(key);
               made++;
            end
         end else begin
            // noise: mostly ignored, so not counted
            run = $urandom_range(8, 1);
            for (i = 0; i < run; i++) keystrokes.push_back(CODE_W'($urandom_range(255)));
         end
      end
   endtask

   task automatic drain;
      while (keystrokes.size() != 0 || req_chan.valid || pending_updates.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_color(input logic [COLOR_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cell_color   = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender: hold the code until taken, advance from the queue
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            pending_updates.push_back(screen_update(req_chan.scan_code));
         if (!req_chan.valid || req_chan.ready) begin
            if (keystrokes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.valid     <= 1'b1;
               req_chan.scan_code <= keystrokes.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each response transaction against the oldest prediction
   always @(posedge clock) begin
      stce_rsp_type seen;
      stce_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.write_valid  = rsp_chan.write_valid;
            seen.write_char   = rsp_chan.write_char;
            seen.write_color  = rsp_chan.write_color;
            seen.write_row    = rsp_chan.write_row;
            seen.write_col    = rsp_chan.write_col;
            seen.cursor_valid = rsp_chan.cursor_valid;
            seen.cursor_row   = rsp_chan.cursor_row;
            seen.cursor_col   = rsp_chan.cursor_col;
            if (pending_updates.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: unexpected response: %s", $realtime, describe(seen));
               mismatch_count++;
            end else begin
               want = pending_updates.pop_front();
               if (seen !== want) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(seen));
                  end
                  mismatch_count++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_chan.valid     = 1'b0;
      req_chan.scan_code = '0;
      rsp_chan.ready     = 1'b0;
      caret_row          = '0;
      caret_col          = '0;
      shift_down         = 1'b0;
      cell_color         = COLOR_RESET;
      mismatch_count     = 0;
      quiet_cycles       = 0;
      send_idle_pct      = 35;
      recv_idle_pct      = 78;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // edges at the home position, dead codes, shift handling, then a few moves
      keystrokes = '{SC_BACKSPACE, SC_LEFT, SC_UP, SC_IGNORED, SC_NULL, SC_ALL_ONES,
                     SC_CAPS, SC_F1, SC_ESC, SC_LSHIFT_MAKE, SC_KEY_A, SC_KEY_1, SC_SPACE,
                     SC_RSHIFT_BREAK, SC_KEY_Z, SC_RSHIFT_MAKE, SC_KEY_Q, SC_LSHIFT_BREAK,
                     SC_SLASH, SC_BACKSPACE, SC_RIGHT, SC_DOWN, SC_ENTER, SC_ESC_BREAK,
                     SC_KEYPAD_STAR};
      drain();

      write_color(8'h00);
      add_random_keystrokes(550);
      drain();

      send_idle_pct = 78;
      recv_idle_pct = 35;
      write_color(8'hFF);
      add_random_keystrokes(550);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_color(COLOR_W'($urandom_range(254, 1)));
      add_random_keystrokes(560);
      drain();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/stce_pkg.sv
hw/rtl/stce_req_if.sv
hw/rtl/stce_rsp_if.sv
hw/rtl/stce_decode.sv
hw/rtl/scancode_text_cursor_engine.sv
hw/rtl/stce_check.sv
sim/scancode_text_cursor_engine_tb.sv
